// ===== rtl/core/lfu_pkg.sv =====
package lfu_pkg;

   localparam int MaxEntries = 16;
   localparam int KeyBits    = 32;
   localparam int ValueBits  = 32;
   localparam int CountBits  = 32;
   localparam int IdxBits    = $clog2(MaxEntries);
   localparam int OccBits    = $clog2(MaxEntries + 1);
   localparam int CapBits    = 5;

   localparam logic CMD_GET = 1'b0;
   localparam logic CMD_PUT = 1'b1;

   localparam logic [CountBits-1:0] COUNT_MAX = '1;

   typedef logic [IdxBits-1:0] idx_type;

   // controller to datapath
   typedef struct packed {
      logic    load;       // capture request
      logic    scan_clr;   // clear scan results
      logic    scan_en;    // examine entry at scan_idx
      idx_type scan_idx;
      logic    do_hit;     // update matched entry
      logic    do_evict;   // evict victim, renumber entries older than it
      logic    do_insert;  // age all valid, write new entry
      logic    ins_victim; // insert at victim slot, else free slot
      logic    emit;       // drive a get result
   } ctl_type;

   // datapath to controller
   typedef struct packed {
      logic is_put;
      logic match;
      logic has_free;
      logic has_victim;
      logic full;      // occupancy >= effective capacity
      logic cap_zero;
   } sts_type;

endpackage

// ===== rtl/core/lfu_ctrl.sv =====
module lfu_ctrl (
   input  logic            clock,
   input  logic            reset,
   input  logic            start,
   output logic            busy,
   input  lfu_pkg::sts_type sts,
   output lfu_pkg::ctl_type ctl
);
   import lfu_pkg::*;

   typedef enum logic [3:0] {
      ST_IDLE   = 4'b0001,
      ST_SCAN   = 4'b0010,
      ST_DECIDE = 4'b0100,
      ST_INSERT = 4'b1000
   } state_type;

   state_type state_ff, state_in;
   idx_type   idx_ff, idx_in;
   logic      vic_ff, vic_in;

   assign busy = (state_ff != ST_IDLE);

   // sequence one item: scan all entries, then update
   always_comb begin
      state_in = state_ff;
      idx_in   = idx_ff;
      vic_in   = vic_ff;
      ctl      = '0;
      ctl.scan_idx = idx_ff;
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               ctl.load     = 1'b1;
               ctl.scan_clr = 1'b1;
               idx_in       = '0;
               state_in     = ST_SCAN;
            end
         end
         ST_SCAN: begin
            ctl.scan_en = 1'b1;
            idx_in      = idx_ff + idx_type'(1);
            if (idx_ff == idx_type'(MaxEntries - 1)) state_in = ST_DECIDE;
         end
         ST_DECIDE: begin
            state_in = ST_IDLE;
            if (!sts.is_put) begin
               ctl.emit   = 1'b1;
               ctl.do_hit = sts.match;
            end else if (sts.cap_zero) begin
               state_in = ST_IDLE;
            end else if (sts.match) begin
               ctl.do_hit = 1'b1;
            end else if (sts.full && sts.has_victim) begin
               ctl.do_evict = 1'b1;
               vic_in       = 1'b1;
               state_in     = ST_INSERT;
            end else if (sts.has_free) begin
               vic_in   = 1'b0;
               state_in = ST_INSERT;
            end
         end
         ST_INSERT: begin
            ctl.do_insert  = 1'b1;
            ctl.ins_victim = vic_ff;
            state_in       = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         idx_ff   <= '0;
         vic_ff   <= 1'b0;
      end else begin
         state_ff <= state_in;
         idx_ff   <= idx_in;
         vic_ff   <= vic_in;
      end
   end

endmodule

// ===== rtl/core/lfu_dpath.sv =====
module lfu_dpath (
   input  logic                              clock,
   input  logic                              reset,
   input  lfu_pkg::ctl_type                  ctl,
   output lfu_pkg::sts_type                  sts,
   input  logic [lfu_pkg::CapBits-1:0]       capacity,
   input  logic                              command,
   input  logic signed [lfu_pkg::KeyBits-1:0]   lookup_key,
   input  logic signed [lfu_pkg::ValueBits-1:0] write_value,
   output logic                              rsp_valid,
   output logic                              hit,
   output logic signed [lfu_pkg::ValueBits-1:0] read_value
);
   import lfu_pkg::*;

   logic [MaxEntries-1:0]  valid_ff, valid_in;
   logic [KeyBits-1:0]     key_ff   [MaxEntries];
   logic [ValueBits-1:0]   val_ff   [MaxEntries];
   logic [CountBits-1:0]   cnt_ff   [MaxEntries];
   idx_type                rank_ff  [MaxEntries];
   logic [OccBits-1:0]     occ_ff, occ_in;

   logic                 cmd_ff;
   logic [KeyBits-1:0]   rkey_ff;
   logic [ValueBits-1:0] rval_ff;

   logic    match_ff, vic_ok_ff, free_ok_ff;
   idx_type match_idx_ff, vic_idx_ff, free_idx_ff;
   logic    out_v_ff, out_hit_ff;
   logic [ValueBits-1:0] out_val_ff;

   logic [OccBits-1:0] cap_eff;
   assign cap_eff = (capacity > CapBits'(MaxEntries)) ? OccBits'(MaxEntries)
                                                      : OccBits'(capacity);

   assign sts.is_put     = (cmd_ff == CMD_PUT);
   assign sts.match      = match_ff;
   assign sts.has_free   = free_ok_ff;
   assign sts.has_victim = vic_ok_ff;
   assign sts.full       = (occ_ff >= cap_eff);
   assign sts.cap_zero   = (cap_eff == '0);

   // one entry per cycle: key compare, victim compare, first free slot
   idx_type s;
   logic    s_better;
   assign s = ctl.scan_idx;
   assign s_better = !vic_ok_ff || (cnt_ff[s] < cnt_ff[vic_idx_ff]) ||
                     ((cnt_ff[s] == cnt_ff[vic_idx_ff]) &&
                      (rank_ff[s] > rank_ff[vic_idx_ff]));

   always_ff @(posedge clock) begin
      if (reset) begin
         match_ff   <= 1'b0;
         vic_ok_ff  <= 1'b0;
         free_ok_ff <= 1'b0;
      end else if (ctl.scan_clr) begin
         match_ff   <= 1'b0;
         vic_ok_ff  <= 1'b0;
         free_ok_ff <= 1'b0;
      end else if (ctl.scan_en) begin
         if (valid_ff[s] && key_ff[s] == rkey_ff && !match_ff) begin
            match_ff     <= 1'b1;
            match_idx_ff <= s;
         end
         if (valid_ff[s] && s_better) begin
            vic_ok_ff  <= 1'b1;
            vic_idx_ff <= s;
         end
         if (!valid_ff[s] && !free_ok_ff) begin
            free_ok_ff  <= 1'b1;
            free_idx_ff <= s;
         end
      end
   end

   // hold the request
   always_ff @(posedge clock) begin
      if (ctl.load) begin
         cmd_ff  <= command;
         rkey_ff <= lookup_key;
         rval_ff <= write_value;
      end
   end

   idx_type ins_idx;
   assign ins_idx = ctl.ins_victim ? vic_idx_ff : free_idx_ff;

   always_comb begin
      valid_in = valid_ff;
      occ_in   = occ_ff;
      if (ctl.do_evict) begin
         valid_in[vic_idx_ff] = 1'b0;
         occ_in = occ_ff - OccBits'(1);
      end
      if (ctl.do_insert) begin
         valid_in[ins_idx] = 1'b1;
         occ_in = occ_ff + OccBits'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
         occ_ff   <= '0;
      end else begin
         valid_ff <= valid_in;
         occ_ff   <= occ_in;
      end
   end

   // update entry tables
   always_ff @(posedge clock) begin
      for (int i = 0; i < MaxEntries; i++) begin
         if (ctl.do_hit && valid_ff[i]) begin
            if (idx_type'(i) == match_idx_ff) begin
               rank_ff[i] <= '0;
               if (cnt_ff[i] != COUNT_MAX) cnt_ff[i] <= cnt_ff[i] + CountBits'(1);
               if (cmd_ff == CMD_PUT) val_ff[i] <= rval_ff;
            end else if (rank_ff[i] < rank_ff[match_idx_ff]) begin
               rank_ff[i] <= rank_ff[i] + idx_type'(1);
            end
         end
         if (ctl.do_evict && valid_ff[i] && rank_ff[i] > rank_ff[vic_idx_ff])
            rank_ff[i] <= rank_ff[i] - idx_type'(1);
         if (ctl.do_insert) begin
            if (idx_type'(i) == ins_idx) begin
               rank_ff[i] <= '0;
               cnt_ff[i]  <= CountBits'(1);
               key_ff[i]  <= rkey_ff;
               val_ff[i]  <= rval_ff;
            end else if (valid_ff[i]) begin
               rank_ff[i] <= rank_ff[i] + idx_type'(1);
            end
         end
      end
   end

   // register the get result
   always_ff @(posedge clock) begin
      if (reset) out_v_ff <= 1'b0;
      else       out_v_ff <= ctl.emit;
      if (ctl.emit) begin
         out_hit_ff <= match_ff;
         out_val_ff <= match_ff ? val_ff[match_idx_ff] : '0;
      end
   end

   assign rsp_valid  = out_v_ff;
   assign hit        = out_hit_ff;
   assign read_value = out_val_ff;

endmodule

// ===== rtl/core/lfu_cache_table_top.sv =====
// Channel  | Ports                                         | Direction
// request  | start, busy, req_command/lookup_key/write_value | in (busy out)
// result   | rsp_valid, rsp_hit, rsp_read_value            | out
// config   | csr_psel/penable/pwrite/paddr/pwdata/prdata/pready | in/out
// An item is accepted in the idle state; the scan state then reads the
// entry table one entry a cycle for key match, victim and free slot, the
// decide state updates, an insert also passes through the insert state,
// and the block returns to idle, where start is sampled again. A get
// result is registered and shows in the cycle after the decision.
// Reset is synchronous and empties the table; capacity returns to 16.
// The result receiver cannot stall; busy holds off new items.
module lfu_cache_table_top (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic        req_command,
   input  logic signed [lfu_pkg::KeyBits-1:0]   req_lookup_key,
   input  logic signed [lfu_pkg::ValueBits-1:0] req_write_value,
   output logic        rsp_valid,
   output logic        rsp_hit,
   output logic signed [lfu_pkg::ValueBits-1:0] rsp_read_value,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [1:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);
   import lfu_pkg::*;

   localparam logic [1:0] REG_CAPACITY = 2'd0;

   logic [CapBits-1:0] cap_ff;
   ctl_type ctl;
   sts_type sts;

   assign csr_pready = 1'b1;
   assign csr_prdata = (csr_paddr == REG_CAPACITY) ? 32'(cap_ff) : '0;

   // write capacity register
   always_ff @(posedge clock) begin
      if (reset) cap_ff <= CapBits'(MaxEntries);
      else if (csr_psel && csr_penable && csr_pwrite && csr_paddr == REG_CAPACITY)
         cap_ff <= csr_pwdata[CapBits-1:0];
   end

   lfu_ctrl u_ctrl (
      .clock (clock), .reset (reset), .start (start), .busy (busy),
      .sts (sts), .ctl (ctl)
   );

   lfu_dpath u_dpath (
      .clock (clock), .reset (reset), .ctl (ctl), .sts (sts),
      .capacity (cap_ff), .command (req_command),
      .lookup_key (req_lookup_key), .write_value (req_write_value),
      .rsp_valid (rsp_valid), .hit (rsp_hit), .read_value (rsp_read_value)
   );

endmodule

// ===== verif/testbench.sv =====
module testbench;
   import lfu_pkg::*;

   logic                        clock = 1'b0;
   logic                        reset = 1'b1;
   logic                        start = 1'b0;
   logic                        busy;
   logic                        req_command = CMD_GET;
   logic signed [KeyBits-1:0]   req_lookup_key = '0;
   logic signed [ValueBits-1:0] req_write_value = '0;
   logic                        rsp_valid;
   logic                        rsp_hit;
   logic signed [ValueBits-1:0] rsp_read_value;
   logic                        csr_psel = 1'b0;
   logic                        csr_penable = 1'b0;
   logic                        csr_pwrite = 1'b0;
   logic [1:0]                  csr_paddr = '0;
   logic [31:0]                 csr_pwdata = '0;
   logic [31:0]                 csr_prdata;
   logic                        csr_pready;

   localparam logic [1:0] ADDR_CAPACITY = 2'd0;

   typedef struct packed {
      logic                 hit;
      logic [ValueBits-1:0] value;
   } lookup_type;

   // shadow copy of the cache
   logic [CapBits-1:0]   cap_shadow;
   logic                 slot_valid [MaxEntries];
   logic [KeyBits-1:0]   slot_key   [MaxEntries];
   logic [ValueBits-1:0] slot_value [MaxEntries];
   logic [CountBits-1:0] slot_count [MaxEntries];
   int unsigned          slot_rank  [MaxEntries];
   int unsigned          fill;

   lookup_type lookup_q[$];
   int         errors = 0;
   int         send_idle = 0;
   logic [KeyBits-1:0] key_pool [8];

   lfu_cache_table_top u_top (.*);

   initial begin
      forever #4 clock = ~clock;
   end

   initial begin
      #20000000;
      $display("TEST FAILED");
      $finish;
   end

   task automatic report_mismatch(input string what, input logic [63:0] got,
                                  input logic [63:0] want);
      errors++;
      $display("mismatch %s: got %h want %h at %0t", what, got, want, $realtime);
   endtask

   function automatic void model_clear();
      cap_shadow = 5'd16;
      fill = 0;
      for (int i = 0; i < MaxEntries; i++) begin
         slot_valid[i] = 1'b0;
         slot_count[i] = '0;
         slot_rank[i] = 0;
      end
   endfunction

   // make entry e most recent and raise its count
   function automatic void model_bump(input int e);
      if (slot_count[e] != COUNT_MAX) slot_count[e]++;
      for (int i = 0; i < MaxEntries; i++)
         if (slot_valid[i] && slot_rank[i] < slot_rank[e]) slot_rank[i]++;
      slot_rank[e] = 0;
   endfunction

   // advance the shadow cache by one item; return 1 if it gives a lookup
   function automatic bit cache_predict(input logic cmd, input logic [KeyBits-1:0] key,
                                        input logic [ValueBits-1:0] val,
                                        output lookup_type res);
      int e, v, slot;
      int unsigned cap;
      e = -1;
      v = -1;
      slot = -1;
      cap = (cap_shadow > MaxEntries) ? MaxEntries : cap_shadow;
      res = '0;
      for (int i = MaxEntries - 1; i >= 0; i--)
         if (slot_valid[i] && slot_key[i] == key) e = i;
      if (cmd == CMD_GET) begin
         if (e >= 0) begin
            model_bump(e);
            res.hit = 1'b1;
            res.value = slot_value[e];
         end
         return 1;
      end
      if (cap == 0) return 0;
      if (e >= 0) begin
         slot_value[e] = val;
         model_bump(e);
         return 0;
      end
      if (fill >= cap) begin
         for (int i = 0; i < MaxEntries; i++) begin
            if (!slot_valid[i]) continue;
            if (v < 0 || slot_count[i] < slot_count[v] ||
                (slot_count[i] == slot_count[v] && slot_rank[i] > slot_rank[v]))
               v = i;
         end
         if (v >= 0) begin
            for (int i = 0; i < MaxEntries; i++)
               if (slot_valid[i] && slot_rank[i] > slot_rank[v]) slot_rank[i]--;
            slot_valid[v] = 1'b0;
            fill--;
            slot = v;
         end
      end
      if (slot < 0)
         for (int i = MaxEntries - 1; i >= 0; i--)
            if (!slot_valid[i]) slot = i;
      if (slot < 0) return 0;
      for (int i = 0; i < MaxEntries; i++)
         if (slot_valid[i]) slot_rank[i]++;
      slot_valid[slot] = 1'b1;
      slot_key[slot] = key;
      slot_value[slot] = val;
      slot_count[slot] = 1;
      slot_rank[slot] = 0;
      fill++;
      return 0;
   endfunction

   // check each result against the oldest lookup
   always @(posedge clock) begin
      if (!reset && rsp_valid) begin
         if (lookup_q.size() == 0) begin
            report_mismatch("unexpected result", 64'({rsp_hit, rsp_read_value}), '0);
         end else begin
            lookup_type want;
            want = lookup_q.pop_front();
            if (rsp_hit !== want.hit)
               report_mismatch("hit", 64'(rsp_hit), 64'(want.hit));
            if (rsp_read_value !== want.value)
               report_mismatch("read_value", 64'(rsp_read_value), 64'(want.value));
         end
      end
   end

   task automatic send_item(input logic cmd, input logic [KeyBits-1:0] key,
                            input logic [ValueBits-1:0] val);
      lookup_type res;
      if (send_idle > 0 && $urandom_range(99) < send_idle)
         repeat ($urandom_range(6, 1)) @(posedge clock);
      start <= 1'b1;
      req_command <= cmd;
      req_lookup_key <= key;
      req_write_value <= val;
      @(posedge clock);
      while (busy) @(posedge clock);
      if (cache_predict(cmd, key, val, res)) lookup_q.push_back(res);
      start <= 1'b0;
      // drop start so that the idle block does not take the item again
      @(posedge clock);
   endtask

   // let the block drain before touching the register
   task automatic wait_idle();
      while (lookup_q.size() != 0 || busy) @(posedge clock);
      repeat (24) @(posedge clock);
   endtask

   task automatic write_capacity(input logic [CapBits-1:0] cap);
      wait_idle();
      csr_psel <= 1'b1;
      csr_pwrite <= 1'b1;
      csr_paddr <= ADDR_CAPACITY;
      csr_pwdata <= {$urandom} & ~32'h1f | 32'(cap);
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      cap_shadow = cap;
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      @(posedge clock);
   endtask

   task automatic test_directed();
      send_item(CMD_GET, 32'h0, 32'h0);
      send_item(CMD_PUT, 32'h7fffffff, 32'h80000000);
      send_item(CMD_PUT, 32'h80000000, 32'h7fffffff);
      send_item(CMD_PUT, 32'hffffffff, 32'hffffffff);
      send_item(CMD_PUT, 32'h0, 32'h0);
      send_item(CMD_GET, 32'h7fffffff, 32'h1);
      send_item(CMD_GET, 32'h80000000, 32'h0);
      send_item(CMD_GET, 32'hffffffff, 32'h0);
      send_item(CMD_PUT, 32'h0, 32'h12345678);
      send_item(CMD_GET, 32'h0, 32'h0);
      send_item(CMD_GET, 32'h5, 32'h0);
      // capacity zero ignores puts but still looks up
      write_capacity(5'd0);
      send_item(CMD_PUT, 32'h9, 32'h9);
      send_item(CMD_GET, 32'h9, 32'h0);
      send_item(CMD_GET, 32'h0, 32'h0);
      // capacity below occupancy: evict one, insert one
      write_capacity(5'd2);
      send_item(CMD_PUT, 32'h11, 32'h11);
      send_item(CMD_GET, 32'h7fffffff, 32'h0);
      send_item(CMD_GET, 32'h11, 32'h0);
      // capacity above the table size acts as full size
      write_capacity(5'd31);
      for (int i = 0; i < 18; i++) send_item(CMD_PUT, i + 100, i);
      send_item(CMD_GET, 32'd100, 32'h0);
      send_item(CMD_GET, 32'd117, 32'h0);
   endtask

   task automatic test_random(input int count, input int idle);
      logic [KeyBits-1:0] key;
      send_idle = idle;
      for (int i = 0; i < count; i++) begin
         if ($urandom_range(9) == 0) key = $urandom;
         else key = key_pool[$urandom_range(7)] + $urandom_range(3);
         send_item(1'($urandom_range(1)), key, $urandom);
      end
      send_idle = 0;
   endtask

   task automatic test_capacity_sweep();
      logic [CapBits-1:0] caps [6] = '{5'd1, 5'd16, 5'd3, 5'd0, 5'd8, 5'd17};
      foreach (caps[c]) begin
         write_capacity(caps[c]);
         test_random(150, (c % 2) ? 77 : 0);
      end
   endtask

   initial begin
      model_clear();
      foreach (key_pool[i]) key_pool[i] = $urandom;
      key_pool[0] = 32'h0;
      key_pool[1] = 32'hfffffffc;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_random(300, 0);
      test_random(300, 77);
      test_random(100, 6);
      test_capacity_sweep();
      wait_idle();
      if (errors == 0) $display("TEST PASSED");
      else $display("TEST FAILED");
      $finish;
   end

endmodule

// ===== lfu_cache_table_top.f =====
rtl/core/lfu_pkg.sv
rtl/core/lfu_ctrl.sv
rtl/core/lfu_dpath.sv
rtl/core/lfu_cache_table_top.sv
verif/testbench.sv
